>>> rtl/rtcadj_pkg.sv
// Shared types, constants and helper functions for the RTC BCD time adjuster.
// No dependencies; used by rtcadj_serdiv and rtc_bcd_time_adjust_core.
`default_nettype none

package rtcadj_pkg;

    localparam logic [31:0] DAY_SECS  = 32'd86400;
    localparam logic [31:0] HOUR_SECS = 32'd3600;
    localparam logic [31:0] MIN_SECS  = 32'd60;
    localparam logic [31:0] MAX_SECS  = 32'd3155759999;

    // Command to the serial divider: a pre-shifted divisor and the quotient width.
    typedef struct packed {
        logic        go;
        logic [32:0] divisor;
        logic [4:0]  nbits;
    } t_div_cmd;

    // Response from the serial divider.
    typedef struct packed {
        logic        done;
        logic [15:0] quo;
        logic [31:0] rem;
    } t_div_rsp;

    // Decode a BCD byte as high * 10 + low, even for low digits above nine.
    function automatic logic [7:0] bcd_dec(input logic [7:0] v);
        logic [7:0] hi;
        hi = {4'b0, v[7:4]};
        return (hi << 3) + (hi << 1) + {4'b0, v[3:0]};
    endfunction

    // Encode a value below 100 as two BCD digits.
    function automatic logic [7:0] bcd_enc(input logic [6:0] v);
        logic [14:0] p;
        logic [3:0]  t;
        logic [6:0]  tt;
        logic [6:0]  lo;
        p  = {8'b0, v} * 15'd205;
        t  = p[14:11];
        tt = ({3'b0, t} << 3) + ({3'b0, t} << 1);
        lo = v - tt;
        return {t, lo[3:0]};
    endfunction

    // Leap year test for year 2000 + y, valid for y up to 199.
    function automatic logic is_leap(input logic [7:0] y);
        return (y[1:0] == 2'b00) && (y != 8'd100);
    endfunction

    // Length of month m (1 to 12).
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        case (m)
            4'd2:    d = leap ? 5'd29 : 5'd28;
            4'd4:    d = 5'd30;
            4'd6:    d = 5'd30;
            4'd9:    d = 5'd30;
            4'd11:   d = 5'd30;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

>>> rtl/rtc_bcd_time_adjust_core.sv
// Top level of the RTC BCD time adjuster: sequencer, accumulator and output registers.
// Depends on rtcadj_pkg and rtcadj_serdiv.
`default_nettype none

// Usage:
// A transaction is accepted at a rising edge with start high and busy low. The six
// BCD clock registers and a signed offset in seconds are sampled at that edge, and
// busy stays high until the result is delivered. The result appears on the o_new_*
// ports and o_clamped for exactly one cycle, marked by o_valid; the receiver cannot
// stall, so it must take the result in that cycle. Only one transaction is in
// flight at a time.
// Sequence: the whole years before the input year (since 2000, up to 165 after BCD
// decode) are summed one per cycle, then the months before the input month, clamped
// to 12, and then the time of day is added in. The day count is multiplied by the
// seconds in a day through one shift-add accumulator, and the day, hour and minute
// splits run on one shared serial divider. The result years and months are then
// peeled off one per cycle.
// Reset (synchronous, active low) returns the sequencer to idle and drops o_valid.
// Busy is already low in the o_valid cycle, so the next transaction can be accepted
// at the edge that ends it.
module rtc_bcd_time_adjust_core
    import rtcadj_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [7:0]  i_sec_reg,
    input  wire logic [7:0]  i_min_reg,
    input  wire logic [7:0]  i_hour_reg,
    input  wire logic [7:0]  i_date_reg,
    input  wire logic [7:0]  i_month_reg,
    input  wire logic [7:0]  i_year_reg,
    input  wire logic signed [31:0] i_delta_seconds,
    output logic             o_valid,
    output logic [6:0]       o_new_sec,
    output logic [6:0]       o_new_min,
    output logic [5:0]       o_new_hour,
    output logic [0:0]       o_new_weekday,
    output logic [5:0]       o_new_date,
    output logic [4:0]       o_new_month,
    output logic [7:0]       o_new_year,
    output logic [0:0]       o_clamped
);

    typedef enum logic [3:0] {
        S_IDLE, S_YSUM, S_MSUM, S_ACC1, S_ACC2, S_ACC3, S_MUL, S_CLAMP,
        S_DDAY, S_DHR, S_DMIN, S_YSPLIT, S_MSPLIT, S_DONE
    } t_state;

    t_state             r_state;
    logic [6:0]         r_sec;
    logic [7:0]         r_min;
    logic [5:0]         r_hour;
    logic [7:0]         r_date;
    logic [3:0]         r_mon;
    logic [7:0]         r_year;
    logic signed [31:0] r_delta;
    logic [7:0]         r_cnt;
    logic [16:0]        r_days;
    logic signed [35:0] r_acc;
    logic [35:0]        r_mulk;
    logic [4:0]         r_bits;
    logic [31:0]        r_dvd;
    logic               r_clamp;
    t_div_cmd           r_cmd;
    t_div_rsp           div_rsp;
    logic               r_valid;
    logic [6:0]         r_o_sec;
    logic [6:0]         r_o_min;
    logic [5:0]         r_o_hour;
    logic [5:0]         r_o_date;
    logic [4:0]         r_o_month;
    logic [7:0]         r_o_year;

    logic [7:0]         dec_mon;
    logic [8:0]         year_len;
    logic [4:0]         cur_mlen;
    logic [7:0]         enc_sec;
    logic [7:0]         enc_min;
    logic [7:0]         enc_hour;
    logic [7:0]         enc_date;
    logic [7:0]         enc_month;
    logic [7:0]         enc_year;

    // Month decode, plus year and month lengths shared by the year and month loops.
    assign dec_mon  = bcd_dec({3'b0, i_month_reg[4:0]});
    assign year_len = is_leap(r_cnt) ? 9'd366 : 9'd365;
    assign cur_mlen = month_len(r_cnt[3:0], is_leap(r_year));

    // BCD encoding of the final fields.
    assign enc_sec   = bcd_enc(r_sec);
    assign enc_min   = bcd_enc(r_min[6:0]);
    assign enc_hour  = bcd_enc({1'b0, r_hour});
    assign enc_date  = bcd_enc(r_days[6:0] + 7'd1);
    assign enc_month = bcd_enc({3'b0, r_mon});
    assign enc_year  = bcd_enc(r_year[6:0]);

    rtcadj_serdiv u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (r_cmd),
        .i_dividend (r_dvd),
        .o_rsp      (div_rsp)
    );

    // Sequencer with its working and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= 1'b0;
            r_cmd.go <= 1'b0;
        end else begin
            r_valid  <= 1'b0;
            r_cmd.go <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_sec   <= 7'(bcd_dec({1'b0, i_sec_reg[6:0]}));
                        r_min   <= bcd_dec(i_min_reg);
                        r_hour  <= 6'(bcd_dec({2'b0, i_hour_reg[5:0]}));
                        r_date  <= bcd_dec(i_date_reg);
                        r_mon   <= (dec_mon > 8'd12) ? 4'd12 : dec_mon[3:0];
                        r_year  <= bcd_dec(i_year_reg);
                        r_delta <= i_delta_seconds;
                        r_cnt   <= '0;
                        r_days  <= '0;
                        r_clamp <= 1'b0;
                        r_state <= S_YSUM;
                    end
                end
                // Whole years before the input year.
                S_YSUM: begin
                    if (r_cnt < r_year) begin
                        r_days <= r_days + {8'b0, year_len};
                        r_cnt  <= r_cnt + 8'd1;
                    end else begin
                        r_cnt   <= 8'd1;
                        r_state <= S_MSUM;
                    end
                end
                // Whole months before the input month, then the day of month.
                S_MSUM: begin
                    if (r_cnt < {4'b0, r_mon}) begin
                        r_days <= r_days + {12'b0, cur_mlen};
                        r_cnt  <= r_cnt + 8'd1;
                    end else begin
                        r_days  <= r_days + {9'b0, r_date};
                        r_state <= S_ACC1;
                    end
                end
                // The day count includes the current day, so one day is taken back here.
                S_ACC1: begin
                    r_acc   <= 36'(r_delta) + $signed({29'b0, r_sec})
                               - $signed({4'b0, DAY_SECS});
                    r_state <= S_ACC2;
                end
                S_ACC2: begin
                    r_acc   <= r_acc + $signed({22'b0, 14'(r_min) * 14'd60});
                    r_state <= S_ACC3;
                end
                S_ACC3: begin
                    r_acc   <= r_acc + $signed({18'b0, 18'(r_hour) * 18'd3600});
                    r_mulk  <= {4'b0, DAY_SECS};
                    r_bits  <= 5'd17;
                    r_state <= S_MUL;
                end
                // Shift-add multiply of the day count by the seconds in a day.
                S_MUL: begin
                    if (r_days[0]) begin
                        r_acc <= r_acc + $signed(r_mulk);
                    end
                    r_mulk <= r_mulk << 1;
                    r_days <= r_days >> 1;
                    r_bits <= r_bits - 5'd1;
                    if (r_bits == 5'd1) begin
                        r_state <= S_CLAMP;
                    end
                end
                // Saturate at the first second of 2000 and the last second of 2099.
                S_CLAMP: begin
                    if (r_acc[35]) begin
                        r_dvd   <= '0;
                        r_clamp <= 1'b1;
                    end else if (r_acc > $signed({4'b0, MAX_SECS})) begin
                        r_dvd   <= MAX_SECS;
                        r_clamp <= 1'b1;
                    end else begin
                        r_dvd <= r_acc[31:0];
                    end
                    r_cmd.go      <= 1'b1;
                    r_cmd.divisor <= {1'b0, DAY_SECS} << 15;
                    r_cmd.nbits   <= 5'd16;
                    r_state       <= S_DDAY;
                end
                S_DDAY: begin
                    if (div_rsp.done) begin
                        r_days        <= {1'b0, div_rsp.quo};
                        r_dvd         <= div_rsp.rem;
                        r_cmd.go      <= 1'b1;
                        r_cmd.divisor <= {1'b0, HOUR_SECS} << 4;
                        r_cmd.nbits   <= 5'd5;
                        r_state       <= S_DHR;
                    end
                end
                S_DHR: begin
                    if (div_rsp.done) begin
                        r_hour        <= div_rsp.quo[5:0];
                        r_dvd         <= div_rsp.rem;
                        r_cmd.go      <= 1'b1;
                        r_cmd.divisor <= {1'b0, MIN_SECS} << 5;
                        r_cmd.nbits   <= 5'd6;
                        r_state       <= S_DMIN;
                    end
                end
                S_DMIN: begin
                    if (div_rsp.done) begin
                        r_min   <= div_rsp.quo[7:0];
                        r_sec   <= div_rsp.rem[6:0];
                        r_cnt   <= '0;
                        r_state <= S_YSPLIT;
                    end
                end
                // Peel whole years off the day count.
                S_YSPLIT: begin
                    if (r_days < {8'b0, year_len}) begin
                        r_year  <= r_cnt;
                        r_cnt   <= 8'd1;
                        r_state <= S_MSPLIT;
                    end else begin
                        r_days <= r_days - {8'b0, year_len};
                        r_cnt  <= r_cnt + 8'd1;
                    end
                end
                // Peel whole months off; December takes whatever is left.
                S_MSPLIT: begin
                    if (r_days < {12'b0, cur_mlen} || r_cnt >= 8'd12) begin
                        r_mon   <= r_cnt[3:0];
                        r_state <= S_DONE;
                    end else begin
                        r_days <= r_days - {12'b0, cur_mlen};
                        r_cnt  <= r_cnt + 8'd1;
                    end
                end
                S_DONE: begin
                    r_o_sec   <= enc_sec[6:0];
                    r_o_min   <= enc_min[6:0];
                    r_o_hour  <= enc_hour[5:0];
                    r_o_date  <= enc_date[5:0];
                    r_o_month <= enc_month[4:0];
                    r_o_year  <= enc_year;
                    r_valid   <= 1'b1;
                    r_state   <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_new_sec     = r_o_sec;
    assign o_new_min     = r_o_min;
    assign o_new_hour    = r_o_hour;
    assign o_new_weekday = 1'b1;
    assign o_new_date    = r_o_date;
    assign o_new_month   = r_o_month;
    assign o_new_year    = r_o_year;
    assign o_clamped     = r_clamp;

endmodule

`default_nettype wire

>>> rtl/rtcadj_serdiv.sv
// Restoring divider that produces one quotient bit per cycle.
// Depends on rtcadj_pkg for the command and response types.
`default_nettype none

module rtcadj_serdiv
    import rtcadj_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_div_cmd    i_cmd,
    input  wire logic [31:0] i_dividend,
    output t_div_rsp         o_rsp
);

    logic [31:0] r_rem;
    logic [32:0] r_dsr;
    logic [15:0] r_quo;
    logic [4:0]  r_cnt;
    logic        r_done;
    logic        ge;

    // Trial subtraction against the divisor at the current bit position.
    assign ge = {1'b0, r_rem} >= r_dsr;

    // Control state: bit counter and completion strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.go) begin
                r_cnt <= i_cmd.nbits;
            end else if (r_cnt != 5'd0) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder, shifting divisor and quotient.
    always_ff @(posedge i_clk) begin
        if (i_cmd.go) begin
            r_rem <= i_dividend;
            r_dsr <= i_cmd.divisor;
            r_quo <= '0;
        end else if (r_cnt != 5'd0) begin
            if (ge) begin
                r_rem <= r_rem - r_dsr[31:0];
            end
            r_dsr <= r_dsr >> 1;
            r_quo <= {r_quo[14:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

`default_nettype wire

>>> tb/sv/rtc_bcd_time_adjust_core_test.sv
// Self-checking testbench for rtc_bcd_time_adjust_core: directed table plus random traffic.
// Depends on the core RTL; the expected date and time come from a local predictor or a typed-in result.
`timescale 1ns / 100ps

module rtc_bcd_time_adjust_core_test;

    localparam int     CYCLE_LIMIT = 8000000;
    localparam longint DAY_S       = 86400;
    localparam longint LAST_S      = 64'd3155759999;
    localparam int     N_RANDOM    = 1950;

    // One request to the core.
    typedef struct {
        logic [7:0]  sec;
        logic [7:0]  min;
        logic [7:0]  hour;
        logic [7:0]  date;
        logic [7:0]  month;
        logic [7:0]  year;
        logic [31:0] delta;
    } adj_req_t;

    // One adjusted date and time, in the core's register form.
    typedef struct packed {
        logic [6:0] sec;
        logic [6:0] min;
        logic [5:0] hour;
        logic [0:0] wday;
        logic [5:0] date;
        logic [4:0] month;
        logic [7:0] year;
        logic [0:0] clamped;
    } adj_time_t;

    // A directed row: the request, and a typed-in result where one is given.
    typedef struct {
        adj_req_t  req;
        bit        fixed;
        adj_time_t res;
    } dir_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [7:0]  i_sec_reg;
    logic [7:0]  i_min_reg;
    logic [7:0]  i_hour_reg;
    logic [7:0]  i_date_reg;
    logic [7:0]  i_month_reg;
    logic [7:0]  i_year_reg;
    logic signed [31:0] i_delta_seconds;
    logic        o_valid;
    logic [6:0]  o_new_sec;
    logic [6:0]  o_new_min;
    logic [5:0]  o_new_hour;
    logic [0:0]  o_new_weekday;
    logic [5:0]  o_new_date;
    logic [4:0]  o_new_month;
    logic [7:0]  o_new_year;
    logic [0:0]  o_clamped;

    adj_time_t pending_times[$];
    int        mismatch_count;
    int        result_count;
    int        clamp_count;
    int        cycle_count;
    dir_row_t  dir_rows[$];

    rtc_bcd_time_adjust_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_sec_reg       (i_sec_reg),
        .i_min_reg       (i_min_reg),
        .i_hour_reg      (i_hour_reg),
        .i_date_reg      (i_date_reg),
        .i_month_reg     (i_month_reg),
        .i_year_reg      (i_year_reg),
        .i_delta_seconds (i_delta_seconds),
        .o_valid         (o_valid),
        .o_new_sec       (o_new_sec),
        .o_new_min       (o_new_min),
        .o_new_hour      (o_new_hour),
        .o_new_weekday   (o_new_weekday),
        .o_new_date      (o_new_date),
        .o_new_month     (o_new_month),
        .o_new_year      (o_new_year),
        .o_clamped       (o_clamped)
    );

    // Clock with a 10 ns period.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Gregorian leap rule on a full year number.
    function automatic bit leap_of(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
        int unsigned lens[12];
        lens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        return lens[(m - 1) % 12] + ((m == 2 && leap_of(y)) ? 1 : 0);
    endfunction

    function automatic int unsigned from_bcd(input logic [7:0] v);
        return v[7:4] * 10 + v[3:0];
    endfunction

    function automatic logic [7:0] to_bcd(input int unsigned v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    // Convert the registers to seconds since 2000, add the offset, clamp and split back.
    function automatic adj_time_t shift_time(input adj_req_t r);
        adj_time_t   t;
        int unsigned s, mi, h, d, mo, yr, y, m, rem, dleft, ylen;
        longint      days, total;
        s  = from_bcd({1'b0, r.sec[6:0]});
        mi = from_bcd(r.min);
        h  = from_bcd({2'b0, r.hour[5:0]});
        d  = from_bcd(r.date);
        mo = from_bcd({3'b0, r.month[4:0]});
        yr = 2000 + from_bcd(r.year);
        if (mo > 12) mo = 12;
        days = 0;
        for (y = 2000; y < yr; y++) days += leap_of(y) ? 366 : 365;
        for (m = 1; m < mo; m++) days += days_in_month(m, yr);
        days += longint'(d) - 1;
        total = days * DAY_S + h * 3600 + mi * 60 + s + longint'($signed(r.delta));
        t.clamped = 1'b0;
        if (total < 0) begin
            total = 0;
            t.clamped = 1'b1;
        end else if (total > LAST_S) begin
            total = LAST_S;
            t.clamped = 1'b1;
        end
        dleft = total / DAY_S;
        rem   = total % DAY_S;
        h     = rem / 3600;
        rem   = rem % 3600;
        y = 2000;
        forever begin
            ylen = leap_of(y) ? 366 : 365;
            if (dleft < ylen) break;
            dleft -= ylen;
            y++;
        end
        m = 1;
        while (dleft >= days_in_month(m, y) && m < 12) begin
            dleft -= days_in_month(m, y);
            m++;
        end
        t.sec   = 7'(to_bcd(rem % 60));
        t.min   = 7'(to_bcd(rem / 60));
        t.hour  = 6'(to_bcd(h));
        t.wday  = 1'b1;
        t.date  = 6'(to_bcd(dleft + 1));
        t.month = 5'(to_bcd(m));
        t.year  = to_bcd(y - 2000);
        return t;
    endfunction

    function automatic adj_req_t make_req(input logic [7:0] s, mi, h, d, mo, y,
                                          input logic [31:0] dl);
        adj_req_t r;
        r = '{s, mi, h, d, mo, y, dl};
        return r;
    endfunction

    function automatic adj_time_t make_time(input logic [6:0] s, mi, input logic [5:0] h,
                                            input logic [5:0] d, input logic [4:0] mo,
                                            input logic [7:0] y, input logic c);
        adj_time_t t;
        t = '{s, mi, h, 1'b1, d, mo, y, c};
        return t;
    endfunction

    // Random request: mostly valid calendar values, some raw bytes and boundary offsets.
    function automatic adj_req_t rand_req();
        adj_req_t    r;
        int unsigned kind, mo, yr;
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
            yr = $urandom_range(0, 99);
            mo = $urandom_range(1, 12);
            r.sec   = {1'($urandom), 7'(to_bcd($urandom_range(0, 59)))};
            r.min   = to_bcd($urandom_range(0, 59));
            r.hour  = {2'($urandom), 6'(to_bcd($urandom_range(0, 23)))};
            r.month = {3'($urandom), 5'(to_bcd(mo))};
            r.year  = to_bcd(yr);
            r.date  = to_bcd($urandom_range(1, days_in_month(mo, 2000 + yr)));
        end else begin
            r.sec   = 8'($urandom);
            r.min   = 8'($urandom);
            r.hour  = 8'($urandom);
            r.date  = 8'($urandom);
            r.month = 8'($urandom);
            r.year  = (kind == 9) ? 8'($urandom) : to_bcd($urandom_range(0, 99));
        end
        case ($urandom_range(0, 5))
            0: r.delta = $urandom_range(0, 120) - 60;
            1: r.delta = $urandom_range(0, 200000) - 100000;
            2: r.delta = $urandom_range(0, 80000000) - 40000000;
            3: r.delta = $urandom();
            4: r.delta = $urandom_range(0, 2) ? 32'h8000_0000 + $urandom_range(0, 255)
                                              : 32'h7FFF_FFFF - $urandom_range(0, 255);
            default: r.delta = 32'(DAY_S * $urandom_range(0, 800)) * ($urandom_range(0, 1) ? 1 : -1);
        endcase
        return r;
    endfunction

    // Drive one transaction and hold it until the core takes it; start stays high.
    task automatic send_req(input adj_req_t r, input bit fixed, input adj_time_t res);
        i_sec_reg       <= r.sec;
        i_min_reg       <= r.min;
        i_hour_reg      <= r.hour;
        i_date_reg      <= r.date;
        i_month_reg     <= r.month;
        i_year_reg      <= r.year;
        i_delta_seconds <= r.delta;
        start           <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_times.push_back(fixed ? res : shift_time(r));
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) @(posedge i_clk);
    endtask

    // Compare each strobed result with the oldest expected one.
    always @(posedge i_clk) begin
        adj_time_t want, got;
        if (i_rst_n && o_valid) begin
            got = '{o_new_sec, o_new_min, o_new_hour, o_new_weekday, o_new_date,
                    o_new_month, o_new_year, o_clamped};
            result_count++;
            if (o_clamped) clamp_count++;
            if (pending_times.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("Result with nothing expected: %p", got);
            end else begin
                want = pending_times.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Result %0d: expected %p, got %p", result_count, want, got);
                end
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        adj_time_t no_res;
        adj_req_t  r;
        int        sent, burst, wait_n;
        mismatch_count = 0;
        result_count   = 0;
        clamp_count    = 0;
        cycle_count    = 0;
        no_res         = make_time(0, 0, 0, 0, 0, 0, 0);
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_sec_reg       = '0;
        i_min_reg       = '0;
        i_hour_reg      = '0;
        i_date_reg      = '0;
        i_month_reg     = '0;
        i_year_reg      = '0;
        i_delta_seconds = '0;

        // Directed table: limits, clamps, BCD oddities, month and day edge cases.
        dir_rows.push_back('{make_req(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, 0), 1,
                             make_time(0, 0, 0, 6'h01, 5'h01, 8'h00, 0)});
        dir_rows.push_back('{make_req(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, -1), 1,
                             make_time(0, 0, 0, 6'h01, 5'h01, 8'h00, 1)});
        dir_rows.push_back('{make_req(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 0), 1,
                             make_time(7'h59, 7'h59, 6'h23, 6'h31, 5'h12, 8'h99, 0)});
        dir_rows.push_back('{make_req(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 1), 1,
                             make_time(7'h59, 7'h59, 6'h23, 6'h31, 5'h12, 8'h99, 1)});
        dir_rows.push_back('{make_req(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, 32'h7FFF_FFFF), 0,
                             no_res});
        dir_rows.push_back('{make_req(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 32'h8000_0000), 0,
                             no_res});
        dir_rows.push_back('{make_req(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 0), 1,
                             make_time(0, 0, 0, 6'h01, 5'h01, 8'h00, 1)});
        dir_rows.push_back('{make_req(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0), 1,
                             make_time(7'h59, 7'h59, 6'h23, 6'h31, 5'h12, 8'h99, 1)});
        dir_rows.push_back('{make_req(8'hD9, 8'h00, 8'h12, 8'h15, 8'h06, 8'h24, 0), 0, no_res});
        dir_rows.push_back('{make_req(8'h0F, 8'h7F, 8'h2F, 8'h3F, 8'h0F, 8'h2F, 0), 0, no_res});
        dir_rows.push_back('{make_req(8'h30, 8'h20, 8'h10, 8'h28, 8'h02, 8'h00, 86400), 0,
                             no_res});
        dir_rows.push_back('{make_req(8'h30, 8'h20, 8'h10, 8'h28, 8'h02, 8'h00, 2 * 86400), 0,
                             no_res});
        dir_rows.push_back('{make_req(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00, -1), 0, no_res});
        dir_rows.push_back('{make_req(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h01, -1), 0, no_res});
        dir_rows.push_back('{make_req(8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h10, 0), 0, no_res});
        dir_rows.push_back('{make_req(8'h00, 8'h00, 8'h00, 8'h05, 8'h15, 8'h10, 0), 0, no_res});
        dir_rows.push_back('{make_req(8'h00, 8'h00, 8'h00, 8'h00, 8'h05, 8'h50, 0), 0, no_res});
        dir_rows.push_back('{make_req(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h49, 1), 0, no_res});
        dir_rows.push_back('{make_req(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'hA0, -2000000000), 0,
                             no_res});
        dir_rows.push_back('{make_req(8'h80, 8'hC0, 8'hC0, 8'h29, 8'hE2, 8'h96, 12345), 0,
                             no_res});

        idle_cycles(5);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) send_req(dir_rows[k].req, dir_rows[k].fixed, dir_rows[k].res);

        // Random traffic in bursts, with one full drain partway through.
        sent = 0;
        while (sent < N_RANDOM) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && sent < N_RANDOM; b++) begin
                r = rand_req();
                send_req(r, 0, no_res);
                sent++;
            end
            start <= 1'b0;
            if (sent >= N_RANDOM / 2 && sent - burst < N_RANDOM / 2) begin
                while (pending_times.size() != 0) @(posedge i_clk);
            end
            wait_n = $urandom_range(0, 3) == 0 ? 1 : $urandom_range(1, 400);
            idle_cycles(wait_n);
        end

        while (pending_times.size() != 0) @(posedge i_clk);
        idle_cycles(400);

        $display("Ran %0d transactions (%0d directed), %0d results checked, %0d clamped.",
                 dir_rows.size() + N_RANDOM, dir_rows.size(), result_count, clamp_count);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d mismatching results.", mismatch_count);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
